// File: rtl/twl_pkg.sv
// shared types and constants for the tiling window layout block
// no dependencies; used by twl_divider and tiling_window_layout_core
package twl_pkg;

  localparam int COORD_W    = 13;
  localparam int GAP_W      = 8;
  localparam int RATIO_W    = 7;
  localparam int COUNT_W    = 4;
  localparam int MODE_W     = 3;
  localparam int INDEX_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int DIVIDEND_W = 20;
  localparam int DIVISOR_W  = 7;

  localparam logic [COORD_W-1:0] COORD_MAX      = 13'h1FFF;
  localparam logic [COORD_W-1:0] PANEL_HEIGHT   = 13'd24;
  localparam logic [RATIO_W-1:0] PERCENT_FULL   = 7'd100;

  localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
  localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
  localparam logic [GAP_W-1:0]   RST_GAP_SIZE      = 8'd4;
  localparam logic [RATIO_W-1:0] RST_MASTER_RATIO  = 7'd60;

  typedef enum logic [MODE_W-1:0] {
    LAYOUT_COLUMNS = 3'd0,
    LAYOUT_ROWS    = 3'd1,
    LAYOUT_TILES   = 3'd2,
    LAYOUT_FULL    = 3'd3,
    LAYOUT_MASTER  = 3'd4
  } layout_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_GAP_SIZE      = 3'd2,
    CFG_MASTER_RATIO  = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/twl_divider.sv
// restoring divider, one quotient bit per cycle
// depends on twl_pkg for widths and the request/response structs
module twl_divider
  import twl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dsr_r;

  logic [DIVISOR_W:0]    trial;
  logic                  fits;
  logic [DIVISOR_W:0]    trial_sub;

  assign trial     = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits      = trial >= {1'b0, dsr_r};
  assign trial_sub = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= CNT_LAST;
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: rtl/tiling_window_layout_core.sv
// tiling window layout: config registers, sequencer and rectangle emitter
// depends on twl_pkg and twl_divider
//
// usage:
//   input channel (in_valid / in_stall) takes one request beat: a window count
//   and a layout mode. the count saturates to MAX_WINDOWS; a count of zero is
//   taken and gives no results. in_stall is high while a request is in work.
//   result channel (out_valid / out_stall) gives one rectangle beat per window
//   in window order, with out_last_rect on the final one. an output register
//   holds a stalled beat; the emitter waits while it is full and stalled.
//   config channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata) writes the
//   screen size, gap and master ratio; cfg_ready is always high and writes are
//   to be made only while no request is in work. unknown indexes are ignored.
//   sequence: after the request beat the block passes through prep, then for
//   columns, rows and grid one pass of the shared divider (split, wait), for
//   master plus stack two divider passes (ratio, wait, stack, wait), and for
//   fullscreen and unknown modes none; then load and emit, one rectangle per
//   cycle while the output is not stalled.
//   reset (synchronous, rst_n low) returns the config registers to their defaults,
//   drops any pending beat and leaves the block idle.
module tiling_window_layout_core
  import twl_pkg::*;
#(
  parameter int MAX_WINDOWS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COUNT_W-1:0]   in_window_count,
  input  logic [MODE_W-1:0]    in_layout_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [INDEX_W-1:0]   out_window_index,
  output logic [COORD_W-1:0]   out_rect_x,
  output logic [COORD_W-1:0]   out_rect_y,
  output logic [COORD_W-1:0]   out_rect_width,
  output logic [COORD_W-1:0]   out_rect_height,
  output logic                 out_last_rect,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam logic [COUNT_W:0] MAX_CNT = (COUNT_W+1)'(MAX_WINDOWS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_SPLIT = 8'b0000_0100,
    S_RATIO = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_STACK = 8'b0010_0000,
    S_LOAD  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  function automatic logic [COORD_W-1:0] sat_sub(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [COORD_W-1:0] sat_add(logic [COORD_W-1:0] a,
                                                 logic [COORD_W:0]   b);
    logic [COORD_W+1:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > {2'b0, COORD_MAX}) ? COORD_MAX : s[COORD_W-1:0];
  endfunction

  // configuration registers
  logic [COORD_W-1:0] screen_width_r;
  logic [COORD_W-1:0] screen_height_r;
  logic [GAP_W-1:0]   gap_size_r;
  logic [RATIO_W-1:0] master_ratio_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      gap_size_r      <= RST_GAP_SIZE;
      master_ratio_r  <= RST_MASTER_RATIO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        CFG_GAP_SIZE:      gap_size_r      <= cfg_wdata[GAP_W-1:0];
        CFG_MASTER_RATIO:  master_ratio_r  <= cfg_wdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry from config
  logic [COORD_W-1:0] gap;
  logic [COORD_W-1:0] gap2;
  logic [COORD_W-1:0] gap3;
  logic [COORD_W-1:0] usable;
  logic [COORD_W-1:0] top;
  logic [COORD_W-1:0] full_w;
  logic [COORD_W-1:0] full_h;
  logic [COORD_W-1:0] cell_w;
  logic [RATIO_W-1:0] ratio;

  assign gap    = {{(COORD_W-GAP_W){1'b0}}, gap_size_r};
  assign gap2   = {{(COORD_W-GAP_W-1){1'b0}}, gap_size_r, 1'b0};
  assign gap3   = gap2 + gap;
  assign usable = sat_sub(sat_sub(screen_height_r, PANEL_HEIGHT), gap);
  assign top    = PANEL_HEIGHT + gap;
  assign full_w = sat_sub(screen_width_r, gap2);
  assign full_h = sat_sub(usable, gap);
  assign cell_w = sat_sub(screen_width_r, gap3) >> 1;
  assign ratio  = (master_ratio_r > PERCENT_FULL) ? PERCENT_FULL : master_ratio_r;

  // sequencer state
  state_t             state_r;
  logic               ratio_phase_r;
  logic [COUNT_W-1:0] n_r;
  logic [MODE_W-1:0]  mode_r;
  logic [COORD_W-1:0] prod_r;
  logic [COORD_W-1:0] q_r;
  logic [COORD_W-1:0] mw_r;
  logic [COORD_W-1:0] stw_r;
  logic [COORD_W-1:0] stack_x_r;

  // emitter state
  logic [COUNT_W-1:0] idx_r;
  logic               col_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic [COORD_W-1:0] rw_r;
  logic [COORD_W-1:0] rh_r;
  logic [COORD_W-1:0] alt_w_r;
  logic [COORD_W-1:0] alt_h_r;
  logic [COORD_W:0]   inc_x_r;
  logic [COORD_W:0]   inc_y_r;

  // output register
  logic               out_valid_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic [COORD_W-1:0] out_w_r;
  logic [COORD_W-1:0] out_h_r;
  logic               out_last_r;

  logic               in_fire;
  logic [COUNT_W:0]   n_clip;
  logic [COUNT_W-1:0] rows;
  logic [COUNT_W-1:0] n_minus1;
  logic               emit_fire;
  logic               emit_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign n_clip    = ({1'b0, in_window_count} > MAX_CNT) ? MAX_CNT : {1'b0, in_window_count};
  assign rows      = COUNT_W'(({1'b0, n_r} + 1'b1) >> 1);
  assign n_minus1  = n_r - 1'b1;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = ({1'b0, idx_r} + 1'b1) == {1'b0, n_r};

  // shared multiplier
  logic [COORD_W-1:0]    mul_a;
  logic [RATIO_W-1:0]    mul_b;
  logic [DIVIDEND_W-1:0] mul_p;

  always_comb begin
    mul_a = gap;
    mul_b = RATIO_W'({1'b0, n_r} + 1'b1);
    if (state_r == S_RATIO) begin
      mul_a = screen_width_r;
      mul_b = ratio;
    end else begin
      case (mode_r)
        LAYOUT_TILES:  mul_b = RATIO_W'({1'b0, rows} + 1'b1);
        LAYOUT_MASTER: mul_b = RATIO_W'(n_r);
        default:       mul_b = RATIO_W'({1'b0, n_r} + 1'b1);
      endcase
    end
  end

  assign mul_p = {{(DIVIDEND_W-COORD_W){1'b0}}, mul_a} *
                 {{(DIVIDEND_W-RATIO_W){1'b0}}, mul_b};

  // shared divider
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [COORD_W-1:0] split_num;
  logic [COORD_W-1:0] quo;

  assign quo = div_rsp.quotient[COORD_W-1:0];

  always_comb begin
    split_num = sat_sub(usable, prod_r);
    if (mode_r == LAYOUT_COLUMNS) begin
      split_num = sat_sub(screen_width_r, prod_r);
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIVIDEND_W-COORD_W){1'b0}}, split_num};
    div_req.divisor  = DIVISOR_W'(n_r);
    unique case (state_r)
      S_SPLIT: begin
        div_req.start = 1'b1;
        if (mode_r == LAYOUT_TILES) begin
          div_req.divisor = DIVISOR_W'(rows);
        end
      end
      S_RATIO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p;
        div_req.divisor  = PERCENT_FULL;
      end
      S_STACK: begin
        div_req.start   = 1'b1;
        div_req.divisor = DIVISOR_W'(n_minus1);
      end
      default: ;
    endcase
  end

  twl_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && n_clip != '0) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          case (mode_r) inside
            LAYOUT_COLUMNS, LAYOUT_ROWS, LAYOUT_TILES: state_r <= S_SPLIT;
            LAYOUT_MASTER:                             state_r <= S_RATIO;
            default:                                   state_r <= S_LOAD;
          endcase
        end
        S_SPLIT: state_r <= S_WAIT;
        S_RATIO: state_r <= S_WAIT;
        S_WAIT: begin
          if (div_rsp.done) begin
            state_r <= ratio_phase_r ? S_STACK : S_LOAD;
          end
        end
        S_STACK: state_r <= S_WAIT;
        S_LOAD:  state_r <= S_EMIT;
        S_EMIT: begin
          if (emit_fire && emit_last) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      n_r <= n_clip[COUNT_W-1:0];
      if (in_layout_mode == LAYOUT_MASTER && n_clip == (COUNT_W+1)'(1)) begin
        mode_r <= LAYOUT_FULL;
      end else begin
        mode_r <= in_layout_mode;
      end
    end
    if (state_r == S_PREP) begin
      prod_r <= mul_p[COORD_W-1:0];
    end
    if (state_r == S_SPLIT || state_r == S_STACK) begin
      ratio_phase_r <= 1'b0;
    end
    if (state_r == S_RATIO) begin
      ratio_phase_r <= 1'b1;
    end
    if (state_r == S_WAIT && div_rsp.done) begin
      if (ratio_phase_r) begin
        mw_r <= sat_sub(quo, gap2);
      end else begin
        q_r <= quo;
      end
    end
    if (state_r == S_STACK) begin
      stw_r     <= sat_sub(sat_sub(screen_width_r, mw_r), gap3);
      stack_x_r <= sat_add(mw_r, {1'b0, gap2});
    end
  end

  // rectangle emitter
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      idx_r   <= '0;
      col_r   <= 1'b0;
      x_r     <= (mode_r > LAYOUT_MASTER) ? '0 : gap;
      y_r     <= (mode_r > LAYOUT_MASTER) ? PANEL_HEIGHT : top;
      inc_x_r <= {1'b0, (mode_r == LAYOUT_TILES) ? cell_w : q_r} + {1'b0, gap};
      inc_y_r <= {1'b0, q_r} + {1'b0, gap};
      alt_w_r <= stw_r;
      alt_h_r <= q_r;
      case (mode_r)
        LAYOUT_COLUMNS: begin
          rw_r <= q_r;
          rh_r <= full_h;
        end
        LAYOUT_ROWS: begin
          rw_r <= full_w;
          rh_r <= q_r;
        end
        LAYOUT_TILES: begin
          rw_r <= cell_w;
          rh_r <= q_r;
        end
        LAYOUT_FULL: begin
          rw_r <= full_w;
          rh_r <= full_h;
        end
        LAYOUT_MASTER: begin
          rw_r <= mw_r;
          rh_r <= full_h;
        end
        default: begin
          rw_r <= '0;
          rh_r <= '0;
        end
      endcase
    end else if (emit_fire) begin
      idx_r <= idx_r + 1'b1;
      case (mode_r)
        LAYOUT_COLUMNS: x_r <= sat_add(x_r, inc_x_r);
        LAYOUT_ROWS:    y_r <= sat_add(y_r, inc_y_r);
        LAYOUT_TILES: begin
          col_r <= !col_r;
          if (!col_r) begin
            x_r <= sat_add(x_r, inc_x_r);
          end else begin
            x_r <= gap;
            y_r <= sat_add(y_r, inc_y_r);
          end
        end
        LAYOUT_MASTER: begin
          if (idx_r == '0) begin
            x_r  <= stack_x_r;
            rw_r <= alt_w_r;
            rh_r <= alt_h_r;
          end else begin
            y_r <= sat_add(y_r, inc_y_r);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_index_r <= idx_r[INDEX_W-1:0];
      out_x_r     <= x_r;
      out_y_r     <= y_r;
      out_w_r     <= rw_r;
      out_h_r     <= rh_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_index = out_index_r;
  assign out_rect_x       = out_x_r;
  assign out_rect_y       = out_y_r;
  assign out_rect_width   = out_w_r;
  assign out_rect_height  = out_h_r;
  assign out_last_rect    = out_last_r;

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_window_count != '0 |=> in_stall)
    else $error("request with windows did not start work");

  a_done_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_WAIT)
    else $error("divider finished outside wait state");

  a_no_emit_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> !div_rsp.busy)
    else $error("emitting while divider busy");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> idx_r < n_r)
    else $error("window index beyond count");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && emit_last |=> state_r == S_IDLE && out_valid && out_last_rect)
    else $error("last beat did not return to idle");
`endif

endmodule
